// ----- rtl/core/dssr_pkg.sv -----
// Shared types and codes for the deduplicating sorted key set.
// Used by the channel interfaces, the controller, the memory and the top level.
// No dependencies.
package dssr_pkg;

	localparam int KEY_W    = 32;
	localparam int ACTION_W = 2;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 7;

	localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_READ   = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd2;

	localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
	localparam logic [STATUS_W-1:0] ST_DONE      = 2'd3;

	typedef logic signed [KEY_W-1:0] key_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		key_t                value;
		logic [COUNT_W-1:0]  set_count;
		logic                empty_res;
		logic                last;
	} res_t;

endpackage

// ----- rtl/core/dssr_in_if.sv -----
// Request channel of the sorted key set: action code and key.
// Depends on dssr_pkg.
interface dssr_in_if import dssr_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [ACTION_W-1:0] action;
	key_t                key;

	modport source (output valid, output action, output key, input ready);
	modport sink (input valid, input action, input key, output ready);
endinterface

// ----- rtl/core/dssr_out_if.sv -----
// Result channel of the sorted key set: one word per status or stored key.
// Depends on dssr_pkg.
interface dssr_out_if import dssr_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	key_t                value;
	logic [COUNT_W-1:0]  set_count;
	logic                empty_res;
	logic                last;

	modport source (output valid, output status, output value, output set_count,
		output empty_res, output last, input ready);
	modport sink (input valid, input status, input value, input set_count,
		input empty_res, input last, output ready);
endinterface

// ----- rtl/core/dssr_mem.sv -----
// Key store: one write port and one read port with registered read data.
// Depends on dssr_pkg.
module dssr_mem import dssr_pkg::*; #(
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  key_t                     wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output key_t                     rdata
);

	key_t mem_q [DEPTH];
	key_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/core/dssr_ctrl.sv -----
// Sequencer of the sorted key set: duplicate scan, ordered shift insert, readout and clear.
// Keeps the store sorted ascending. Depends on dssr_pkg and dssr_in_if.
module dssr_ctrl import dssr_pkg::*; #(
	parameter int CAPACITY = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	dssr_in_if.sink                     in,
	output logic                        mem_we,
	output logic [$clog2(CAPACITY)-1:0] mem_waddr,
	output key_t                        mem_wdata,
	output logic [$clog2(CAPACITY)-1:0] mem_raddr,
	input  key_t                        mem_rdata,
	input  logic                        out_free,
	output logic                        push,
	output res_t                        res
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT,
		S_RD_REQ,
		S_RD_DATA,
		S_EMIT
	} state_t;

	state_t          state_q;
	logic [CW-1:0]   occ_q;
	logic [CW-1:0]   idx_q;
	key_t            key_q;
	logic            found_q;
	res_t            res_q;
	logic            rv_s1;
	logic [AW-1:0]   addr_s1;

	logic            issue_scan;
	logic            scan_done;
	logic            hit;
	logic            cmp;
	logic            gt;
	logic            place_key;
	logic            issue_shift;
	logic            rd_last;
	logic [CW-1:0]   occ_inc;

	assign issue_scan  = (state_q == S_SCAN) && (idx_q != occ_q);
	assign scan_done   = (state_q == S_SCAN) && (idx_q == occ_q) && !rv_s1;
	assign hit         = rv_s1 && (mem_rdata == key_q);
	assign cmp         = (state_q == S_SHIFT) && rv_s1;
	assign gt          = mem_rdata > key_q;
	assign place_key   = (cmp && !gt) || ((state_q == S_SHIFT) && !rv_s1 && (idx_q == '0));
	assign issue_shift = (state_q == S_SHIFT) && !place_key && (idx_q != '0);
	assign rd_last     = CW'(idx_q + 1'b1) == occ_q;
	assign occ_inc     = CW'(occ_q + 1'b1);

	always_comb begin
		mem_we    = cmp || place_key;
		mem_waddr = cmp ? AW'(addr_s1 + 1'b1) : '0;
		mem_wdata = place_key ? key_q : mem_rdata;
		if (state_q == S_SHIFT) begin
			mem_raddr = AW'(idx_q - 1'b1);
		end else begin
			mem_raddr = idx_q[AW-1:0];
		end
	end

	assign in.ready = (state_q == S_IDLE);
	assign push     = ((state_q == S_EMIT) || (state_q == S_RD_DATA)) && out_free;

	always_comb begin
		if (state_q == S_RD_DATA) begin
			res.status    = ST_DONE;
			res.value     = mem_rdata;
			res.set_count = COUNT_W'(occ_q);
			res.empty_res = 1'b0;
			res.last      = rd_last;
		end else begin
			res = res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			occ_q   <= '0;
			idx_q   <= '0;
			key_q   <= '0;
			found_q <= 1'b0;
			res_q   <= '0;
			rv_s1   <= 1'b0;
			addr_s1 <= '0;
		end else begin
			rv_s1   <= issue_scan || issue_shift;
			addr_s1 <= mem_raddr;
			case (state_q)
				S_IDLE: begin
					if (in.valid) begin
						key_q   <= in.key;
						idx_q   <= '0;
						found_q <= 1'b0;
						case (in.action)
							ACT_INSERT: begin
								state_q <= S_SCAN;
							end
							ACT_READ: begin
								if (occ_q == '0) begin
									res_q   <= '{ST_DONE, '0, '0, 1'b1, 1'b1};
									state_q <= S_EMIT;
								end else begin
									state_q <= S_RD_REQ;
								end
							end
							ACT_CLEAR: begin
								occ_q   <= '0;
								res_q   <= '{ST_DONE, '0, '0, 1'b0, 1'b1};
								state_q <= S_EMIT;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (hit) begin
						found_q <= 1'b1;
					end
					if (issue_scan) begin
						idx_q <= CW'(idx_q + 1'b1);
					end
					if (scan_done) begin
						if (found_q) begin
							res_q   <= '{ST_DUPLICATE, '0, COUNT_W'(occ_q), 1'b0, 1'b1};
							state_q <= S_EMIT;
						end else if (occ_q == CW'(CAPACITY)) begin
							res_q   <= '{ST_FULL, '0, COUNT_W'(occ_q), 1'b0, 1'b1};
							state_q <= S_EMIT;
						end else begin
							state_q <= S_SHIFT;
						end
					end
				end
				S_SHIFT: begin
					if (issue_shift) begin
						idx_q <= CW'(idx_q - 1'b1);
					end
					if (place_key) begin
						occ_q   <= occ_inc;
						res_q   <= '{ST_INSERTED, '0, COUNT_W'(occ_inc), 1'b0, 1'b1};
						state_q <= S_EMIT;
					end
				end
				S_RD_REQ: begin
					state_q <= S_RD_DATA;
				end
				S_RD_DATA: begin
					if (out_free) begin
						if (rd_last) begin
							state_q <= S_IDLE;
						end else begin
							idx_q   <= CW'(idx_q + 1'b1);
							state_q <= S_RD_REQ;
						end
					end
				end
				S_EMIT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- rtl/core/dedup_set_sorted_readout_core.sv -----
// Top level of the deduplicating key set with sorted readout.
// Depends on dssr_pkg, dssr_in_if, dssr_out_if, dssr_mem and dssr_ctrl.
//
// The in channel takes one word per action: insert a key, read the set, or clear it.
// Action code 3 is taken and dropped without a result. The out channel returns
// one word per insert or clear, and one word per stored key on a read, in
// ascending signed order with last set on the final one. A read of an empty set
// returns a single word with empty_res set.
// One action is worked on at a time; in.ready is high only while the sequencer
// is idle. An insert of a new key runs a duplicate scan over the held keys, then a
// shift from the top that opens the slot for the new key, one memory read and one
// write per cycle. A duplicate, or a key dropped on a full set, ends after the scan;
// an insert into the empty set writes the key to slot 0 with no shift. A read
// fetches each key on the single read port and sends it before it fetches another;
// a clear or a read of the empty set goes straight to its result word.
// The result word sits in an output register, so a stalled receiver only holds the
// sequencer once the next word is ready to go. Reset empties the set at once; the
// store itself is not cleared.
module dedup_set_sorted_readout_core import dssr_pkg::*; #(
	parameter int CAPACITY = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	dssr_in_if.sink    in,
	dssr_out_if.source out
);

	localparam int AW = $clog2(CAPACITY);

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	key_t          mem_wdata;
	logic [AW-1:0] mem_raddr;
	key_t          mem_rdata;
	logic          out_free;
	logic          push;
	res_t          res;
	res_t          res_q;
	logic          valid_q;

	dssr_mem #(
		.DEPTH(CAPACITY)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	dssr_ctrl #(
		.CAPACITY(CAPACITY)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in       (in),
		.mem_we   (mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata),
		.out_free (out_free),
		.push     (push),
		.res      (res)
	);

	assign out_free = !valid_q || out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			res_q   <= '0;
		end else begin
			if (push) begin
				valid_q <= 1'b1;
				res_q   <= res;
			end else if (out.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign out.valid     = valid_q;
	assign out.status    = res_q.status;
	assign out.value     = res_q.value;
	assign out.set_count = res_q.set_count;
	assign out.empty_res = res_q.empty_res;
	assign out.last      = res_q.last;

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> out_free)
		else $error("result pushed while the output register was full");

	a_idle_no_push: assert property (@(posedge clk) disable iff (!arst_n)
		in.ready |-> !push)
		else $error("result pushed while the sequencer was idle");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out.valid |-> (out.set_count <= COUNT_W'(CAPACITY)))
		else $error("set count above capacity");

	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out.valid && out.empty_res) |-> out.last)
		else $error("empty readout word without last");

endmodule
